// ===== src/cwse_pkg.sv =====
package cwse_pkg;

    localparam int WORD_W      = 32;
    localparam int CARRY_W     = 8;
    localparam int SHIFT_W     = 4;
    localparam int WAVE_IDX_W  = 7;
    localparam int WORD_IDX_W  = 4;
    localparam int CFG_W       = 5;
    localparam int MAX_SHIFT   = 8;

    typedef enum logic [1:0] {
        CMD_COLUMN_BEGIN = 2'd0,
        CMD_WORD         = 2'd1,
        CMD_FRAME_END    = 2'd2
    } t_command;

    typedef enum logic [0:0] {
        CFG_FIRST_WORD = 1'b0,
        CFG_END_WORD   = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [WORD_W-1:0]  out_word;
        logic               write_back;
        logic [SHIFT_W-1:0] shift_now;
    } t_result;

    // Stepped triangle: runs of 0, 2, 4, 6, 8, 6, 4, 2, 0 over the wave.
    function automatic logic [SHIFT_W-1:0] wave_shift(input logic [WAVE_IDX_W-1:0] idx);
        logic [SHIFT_W-1:0] s;
        case (idx) inside
            [7'd0:7'd15]:    s = 4'd0;
            [7'd16:7'd27]:   s = 4'd2;
            [7'd28:7'd37]:   s = 4'd4;
            [7'd38:7'd49]:   s = 4'd6;
            [7'd50:7'd77]:   s = 4'd8;
            [7'd78:7'd89]:   s = 4'd6;
            [7'd90:7'd99]:   s = 4'd4;
            [7'd100:7'd111]: s = 4'd2;
            default:         s = 4'd0;
        endcase
        return s;
    endfunction

endpackage

// ===== src/cwse_wave_datapath.sv =====
module cwse_wave_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [1:0]                     i_command,
    input  logic                           i_eye,
    input  logic [cwse_pkg::WORD_IDX_W-1:0] i_word_index,
    input  logic [cwse_pkg::WORD_W-1:0]    i_pixel_word,
    input  logic [cwse_pkg::CFG_W-1:0]     i_first_word,
    input  logic [cwse_pkg::CFG_W-1:0]     i_end_word,
    output cwse_pkg::t_result              o_result
);
    import cwse_pkg::*;

    logic [WAVE_IDX_W-1:0] r_wave_index, n_wave_index;
    logic [SHIFT_W-1:0]    r_column_shift, n_column_shift;
    logic [CARRY_W-1:0]    r_carry [2];
    logic [CARRY_W-1:0]    n_carry [2];

    logic [WAVE_IDX_W-1:0]     wave_next;
    logic [CFG_W-1:0]          widx_ext;
    logic                      in_window;
    logic                      do_shift;
    logic [WORD_W+CARRY_W-1:0] shifted;
    t_command                  cmd;

    assign cmd       = t_command'(i_command);
    assign wave_next = r_wave_index + WAVE_IDX_W'(1);
    assign widx_ext  = CFG_W'(i_word_index);
    // The word index cannot reach the column length, so only the window is checked.
    assign in_window = (widx_ext >= i_first_word) && (widx_ext < i_end_word);
    assign do_shift  = in_window && (r_column_shift != '0) &&
                       (r_column_shift <= SHIFT_W'(MAX_SHIFT));
    // The top byte of the widened word holds the bits that fall out of this word.
    assign shifted   = {{CARRY_W{1'b0}}, i_pixel_word} << r_column_shift;

    always_comb begin
        n_wave_index   = r_wave_index;
        n_column_shift = r_column_shift;
        n_carry        = r_carry;
        o_result       = '0;
        case (cmd)
            CMD_COLUMN_BEGIN: begin
                n_wave_index   = wave_next;
                n_column_shift = wave_shift(wave_next);
                n_carry[0]     = '0;
                n_carry[1]     = '0;
            end
            CMD_WORD: begin
                if (do_shift) begin
                    o_result.out_word   = shifted[WORD_W-1:0] |
                                          WORD_W'(r_carry[i_eye]);
                    o_result.write_back = 1'b1;
                    n_carry[i_eye]      = shifted[WORD_W+CARRY_W-1:WORD_W];
                end else begin
                    o_result.out_word = i_pixel_word;
                end
            end
            CMD_FRAME_END: begin
                n_wave_index = wave_next;
            end
            default: begin
            end
        endcase
        o_result.shift_now = n_column_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_index   <= '0;
            r_column_shift <= '0;
            r_carry[0]     <= '0;
            r_carry[1]     <= '0;
        end else if (i_accept) begin
            r_wave_index   <= n_wave_index;
            r_column_shift <= n_column_shift;
            r_carry        <= n_carry;
        end
    end

endmodule

// ===== src/column_wave_shift_engine_core.sv =====
// Channel  | Handshake                 | Payload
// ---------+---------------------------+---------------------------------------------
// input    | i_in_valid / o_in_stall   | i_command, i_eye, i_word_index, i_pixel_word
// output   | o_out_valid / i_out_stall | o_out_word, o_write_back, o_shift_now
// config   | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// One word per cycle unless stalled; each result is registered in the output
// register, or in the skid register while the output is held. The wave, shift
// and carry registers update at the accepting edge, so the next word may follow
// at once. A skid register behind the output register keeps the input stall
// registered. Reset is synchronous and active low; it clears the wave state, the
// carries and both valid flags, and returns the window registers to their defaults.
module column_wave_shift_engine_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_command,
    input  logic                            i_eye,
    input  logic [cwse_pkg::WORD_IDX_W-1:0] i_word_index,
    input  logic [cwse_pkg::WORD_W-1:0]     i_pixel_word,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [cwse_pkg::WORD_W-1:0]     o_out_word,
    output logic                            o_write_back,
    output logic [cwse_pkg::SHIFT_W-1:0]    o_shift_now,
    input  logic                            i_cfg_we,
    input  logic [0:0]                      i_cfg_index,
    input  logic [cwse_pkg::CFG_W-1:0]      i_cfg_data
);
    import cwse_pkg::*;

    logic [CFG_W-1:0] r_first_word;
    logic [CFG_W-1:0] r_end_word;

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    t_result step_result;
    logic    accept_in;
    logic    out_free;

    assign accept_in = i_in_valid && !r_skid_valid;
    assign out_free  = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_word <= '0;
            r_end_word   <= CFG_W'(13);
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_FIRST_WORD: r_first_word <= i_cfg_data;
                CFG_END_WORD:   r_end_word   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    cwse_wave_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept_in),
        .i_command    (i_command),
        .i_eye        (i_eye),
        .i_word_index (i_word_index),
        .i_pixel_word (i_pixel_word),
        .i_first_word (r_first_word),
        .i_end_word   (r_end_word),
        .o_result     (step_result)
    );

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (out_free) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = step_result;
                n_out_valid = accept_in;
            end
        end else if (accept_in) begin
            // The output word is held, so the new one parks in the skid register.
            n_skid       = step_result;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_in_stall   = r_skid_valid;
    assign o_out_valid  = r_out_valid;
    assign o_out_word   = r_out.out_word;
    assign o_write_back = r_out.write_back;
    assign o_shift_now  = r_out.shift_now;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a word while the output register is empty");

    a_write_needs_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_write_back) |-> (o_shift_now != '0))
        else $error("write-back flagged with zero shift");

    a_shift_from_wave: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_shift_now <= SHIFT_W'(MAX_SHIFT) && !o_shift_now[0]))
        else $error("shift is not a wave table value");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_out_stall) |=> (r_out_valid && !r_skid_valid))
        else $error("skid word not moved into the output register");

endmodule

// ===== tb/column_wave_shift_engine_core_test.sv =====
module column_wave_shift_engine_core_test;
    import cwse_pkg::*;

    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam int PHASE_WORDS = 128;

    typedef struct packed {
        logic [1:0]            cmd;
        logic                  eye;
        logic [WORD_IDX_W-1:0] idx;
        logic [WORD_W-1:0]     word;
    } t_shift_request;

    typedef struct packed {
        t_shift_request req;
        logic           typed;
        t_result        want;
    } t_stim_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [1:0]            i_command;
    logic                  i_eye;
    logic [WORD_IDX_W-1:0] i_word_index;
    logic [WORD_W-1:0]     i_pixel_word;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [WORD_W-1:0]     o_out_word;
    logic                  o_write_back;
    logic [SHIFT_W-1:0]    o_shift_now;
    logic                  i_cfg_we;
    logic [0:0]            i_cfg_index;
    logic [CFG_W-1:0]      i_cfg_data;

    column_wave_shift_engine_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_eye       (i_eye),
        .i_word_index(i_word_index),
        .i_pixel_word(i_pixel_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .o_write_back(o_write_back),
        .o_shift_now (o_shift_now),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Mirror of the block state.
    logic [SHIFT_W-1:0]    wave_steps [128];
    logic [WAVE_IDX_W-1:0] wave_pos;
    logic [SHIFT_W-1:0]    col_shift;
    logic [CARRY_W-1:0]    eye_spill [2];
    logic [CFG_W-1:0]      win_lo;
    logic [CFG_W-1:0]      win_hi;

    t_result   expected_words[$];
    t_stim_row opening_rows[$];

    int fail_count;
    int sent_count;
    int checked_count;
    int writeback_count;
    int column_count;
    int window_count;
    int gap_mode;
    int stall_mode;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic t_result shift_column_word(input t_shift_request r);
        t_result     res;
        logic [39:0] wide;
        res = '0;
        case (r.cmd)
            CMD_COLUMN_BEGIN: begin
                wave_pos     = wave_pos + 1'b1;
                col_shift    = wave_steps[wave_pos];
                eye_spill[0] = '0;
                eye_spill[1] = '0;
                column_count++;
            end
            CMD_WORD: begin
                if ({1'b0, r.idx} >= win_lo && {1'b0, r.idx} < win_hi && col_shift != 0) begin
                    wide             = {8'b0, r.word} << col_shift;
                    res.out_word     = wide[31:0] | {24'b0, eye_spill[r.eye]};
                    eye_spill[r.eye] = wide[39:32];
                    res.write_back   = 1'b1;
                end else begin
                    res.out_word = r.word;
                end
            end
            CMD_FRAME_END: begin
                wave_pos = wave_pos + 1'b1;
            end
            default: begin
            end
        endcase
        res.shift_now = col_shift;
        return res;
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    // Mode 0 never waits, mode 1 waits anywhere in range, mode 2 waits now and then.
    function automatic int draw_wait(input int mode);
        if (mode == 0) begin
            return 0;
        end
        if (mode == 2 && $urandom_range(0, 3) != 0) begin
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    function automatic logic [WORD_W-1:0] pixel_pattern();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 32'h1 << $urandom_range(0, 31);
            3: return ~(32'h1 << $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    function automatic void add_row(input logic [1:0] cmd, input logic eye,
                                    input logic [WORD_IDX_W-1:0] idx,
                                    input logic [WORD_W-1:0] word, input logic typed,
                                    input logic [WORD_W-1:0] ow, input logic wb,
                                    input logic [SHIFT_W-1:0] sh);
        t_stim_row row;
        row.req  = '{cmd: cmd, eye: eye, idx: idx, word: word};
        row.typed = typed;
        row.want = '{out_word: ow, write_back: wb, shift_now: sh};
        opening_rows.push_back(row);
    endfunction

    task automatic send_request(input t_shift_request r, input logic typed,
                                input t_result want);
        int      gap;
        t_result pred;
        if (sent_count % 40 == 0) begin
            gap_mode = $urandom_range(0, 2);
        end
        gap = draw_wait(gap_mode);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_command    <= r.cmd;
        i_eye        <= r.eye;
        i_word_index <= r.idx;
        i_pixel_word <= r.word;
        pred = shift_column_word(r);
        expected_words.push_back(typed ? want : pred);
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sent_count++;
    endtask

    task automatic send_random(input t_shift_request r);
        send_request(r, 1'b0, '0);
    endtask

    task automatic drain_and_idle();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic set_window(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_FIRST_WORD;
        i_cfg_data  <= lo;
        @(posedge i_clk);
        i_cfg_index <= CFG_END_WORD;
        i_cfg_data  <= hi;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        win_lo = lo;
        win_hi = hi;
        window_count++;
    endtask

    // Mostly whole columns: a column begin followed by runs of words for both eyes,
    // with frame-end bursts and loose noise mixed in.
    task automatic play_phase(input int quota);
        int             start_count;
        int             pick;
        int             first_idx;
        int             run_len;
        int             interleave;
        t_shift_request r;
        start_count = sent_count;
        while (sent_count - start_count < quota) begin
            pick = $urandom_range(0, 9);
            if (pick <= 6) begin
                r = '{cmd: CMD_COLUMN_BEGIN, eye: 1'($urandom),
                      idx: WORD_IDX_W'($urandom), word: $urandom};
                send_random(r);
                first_idx  = $urandom_range(0, 15);
                run_len    = $urandom_range(1, 16);
                interleave = $urandom_range(0, 1);
                for (int k = 0; k < run_len * 2; k++) begin
                    r.cmd  = CMD_WORD;
                    r.eye  = interleave ? k[0] : (k >= run_len);
                    r.idx  = WORD_IDX_W'(first_idx + (interleave ? k / 2 : k % run_len));
                    if ($urandom_range(0, 7) == 0) begin
                        r.idx = WORD_IDX_W'($urandom);
                    end
                    r.word = pixel_pattern();
                    send_random(r);
                end
            end else if (pick == 7) begin
                repeat ($urandom_range(1, 12)) begin
                    r = '{cmd: CMD_FRAME_END, eye: 1'($urandom),
                          idx: WORD_IDX_W'($urandom), word: $urandom};
                    send_random(r);
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    r = '{cmd: 2'($urandom_range(0, 3)), eye: 1'($urandom),
                          idx: WORD_IDX_W'($urandom), word: pixel_pattern()};
                    send_random(r);
                end
            end
        end
        drain_and_idle();
    endtask

    task automatic check_result();
        t_result got;
        t_result want;
        got.out_word   = o_out_word;
        got.write_back = o_write_back;
        got.shift_now  = o_shift_now;
        checked_count++;
        if (got.write_back === 1'b1) begin
            writeback_count++;
        end
        if (expected_words.size() == 0) begin
            note_failure($sformatf("word with nothing pending: out_word %h write_back %b shift %0d",
                                   got.out_word, got.write_back, got.shift_now));
        end else begin
            want = expected_words.pop_front();
            if (got.out_word !== want.out_word || got.write_back !== want.write_back ||
                got.shift_now !== want.shift_now) begin
                note_failure($sformatf(
                    "word %0d: out_word %h/%h write_back %b/%b shift %0d/%0d (want/got)",
                    checked_count, want.out_word, got.out_word, want.write_back,
                    got.write_back, want.shift_now, got.shift_now));
            end
        end
    endtask

    initial begin : result_sink
        int hold;
        i_out_stall <= 1'b0;
        forever begin
            if (checked_count % 40 == 0) begin
                stall_mode = $urandom_range(0, 2);
            end
            hold = draw_wait(stall_mode);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            check_result();
        end
    end

    initial begin : watchdog
        #6000000;
        $display("column_wave_shift_engine_core: mismatch");
        $finish;
    end

    initial begin : stimulus
        int          levels [9];
        int          runs [9];
        int          pos;
        int          waited;
        logic [4:0]  lo_set [7];
        logic [4:0]  hi_set [7];
        levels = '{0, 2, 4, 6, 8, 6, 4, 2, 0};
        runs   = '{16, 12, 10, 12, 28, 12, 10, 12, 16};
        pos = 0;
        for (int s = 0; s < 9; s++) begin
            for (int n = 0; n < runs[s]; n++) begin
                wave_steps[pos] = SHIFT_W'(levels[s]);
                pos++;
            end
        end
        wave_pos     = '0;
        col_shift    = '0;
        eye_spill[0] = '0;
        eye_spill[1] = '0;
        win_lo       = 5'd0;
        win_hi       = 5'd13;

        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_command    <= CMD_COLUMN_BEGIN;
        i_eye        <= 1'b0;
        i_word_index <= '0;
        i_pixel_word <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= CFG_FIRST_WORD;
        i_cfg_data   <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Right after reset the shift is zero, so words pass through untouched.
        add_row(CMD_WORD, 1'b0, 4'd0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0, 4'd0);
        add_row(CMD_WORD, 1'b1, 4'd15, 32'h0, 1'b1, 32'h0, 1'b0, 4'd0);
        add_row(CMD_FRAME_END, 1'b1, 4'd15, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0, 4'd0);
        add_row(CMD_UNKNOWN, 1'b1, 4'd15, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0, 4'd0);
        add_row(CMD_COLUMN_BEGIN, 1'b0, 4'd0, 32'h0, 1'b1, 32'h0, 1'b0, 4'd0);
        repeat (13) add_row(CMD_FRAME_END, 1'b0, 4'd0, 32'h0, 1'b1, 32'h0, 1'b0, 4'd0);
        // This column begin lands on the first step of the ramp.
        add_row(CMD_COLUMN_BEGIN, 1'b0, 4'd0, 32'h0, 1'b1, 32'h0, 1'b0, 4'd2);
        add_row(CMD_WORD, 1'b0, 4'd0, 32'hFFFF_FFFF, 1'b0, '0, 1'b0, '0);
        add_row(CMD_WORD, 1'b0, 4'd1, 32'hC000_0001, 1'b0, '0, 1'b0, '0);
        add_row(CMD_WORD, 1'b1, 4'd12, 32'h8000_0000, 1'b0, '0, 1'b0, '0);
        add_row(CMD_WORD, 1'b1, 4'd13, 32'h1234_5678, 1'b0, '0, 1'b0, '0);
        add_row(CMD_WORD, 1'b0, 4'd15, 32'hFFFF_FFFF, 1'b0, '0, 1'b0, '0);
        foreach (opening_rows[i]) begin
            send_request(opening_rows[i].req, opening_rows[i].typed, opening_rows[i].want);
        end
        drain_and_idle();

        play_phase(PHASE_WORDS);
        lo_set = '{5'd0, 5'd0, 5'd16, 5'd16, 5'd4, 5'd7, 5'($urandom_range(0, 16))};
        hi_set = '{5'd16, 5'd0, 5'd16, 5'd0, 5'd9, 5'd7, 5'($urandom_range(0, 16))};
        for (int p = 0; p < 7; p++) begin
            set_window(lo_set[p], hi_set[p]);
            play_phase(PHASE_WORDS);
        end

        waited = 0;
        while (expected_words.size() != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_words.size() != 0) begin
            note_failure($sformatf("%0d words never came out", expected_words.size()));
        end
        repeat (5) @(posedge i_clk);

        $display("Sent %0d words (%0d column begins) under %0d window settings;",
                 sent_count, column_count, window_count + 1);
        $display("checked %0d results, %0d of them write-backs, %0d failures.",
                 checked_count, writeback_count, fail_count);
        if (fail_count == 0) begin
            $display("column_wave_shift_engine_core: match");
        end else begin
            $display("column_wave_shift_engine_core: mismatch");
        end
        $finish;
    end

endmodule
